// File: hdl/rsif_pkg.sv
// shared types, constants and divider modes for the relative strength index filter
`default_nettype none

package rsif_pkg;

  // field widths
  localparam int unsigned PRICE_W      = 32;
  localparam int unsigned PERIOD_REG_W = 8;
  localparam int unsigned RSI_W        = 23;
  localparam int unsigned RSI_FRAC     = 16;
  localparam int unsigned EXTRA_FRAC   = 8;

  // averages are q24.24, saturating
  localparam int unsigned AVG_W = 48;
  localparam int unsigned DEN_W = AVG_W + 1;
  localparam int unsigned ADD_W = PRICE_W + 1 + EXTRA_FRAC;
  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

  // ratio stage: quotient bits above the fraction, enough to hold 100
  localparam int unsigned RSI_PRE = RSI_W - RSI_FRAC;
  localparam int unsigned RSI_SCALE = 100;
  localparam logic [RSI_W-1:0] RSI_FULL = RSI_W'(RSI_SCALE << RSI_FRAC);

  // period limits and reset value
  localparam int unsigned PERIOD_MAX_DEF = 255;
  localparam int unsigned PERIOD_MIN     = 2;
  localparam logic [PERIOD_REG_W-1:0] PERIOD_RST = PERIOD_REG_W'(14);

  // input and output beats
  typedef struct packed {
    logic signed [PRICE_W-1:0] price;
    logic                      series_start;
    logic                      last_sample;
  } sample_t;

  typedef struct packed {
    logic [RSI_W-1:0] rsi_value;
    logic             series_last;
  } result_t;

  // divider job kinds
  typedef enum logic [1:0] {
    DIV_WARM   = 2'd0,
    DIV_SMOOTH = 2'd1,
    DIV_RATIO  = 2'd2
  } div_mode_t;

  typedef struct packed {
    logic      start;
    div_mode_t mode;
  } div_req_t;

endpackage

`default_nettype wire

// File: hdl/rsif_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module rsif_div
  import rsif_pkg::*;
#(
  parameter int unsigned NUM_W  = 57,
  parameter int unsigned STEP_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire div_req_t         req,
  input  wire logic [DEN_W-1:0] rem_init,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quot,
  output logic                  done
);

  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  acc;
  logic [DEN_W-1:0]  dsr;
  logic [STEP_W-1:0] cnt;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    trial;
  logic              qbit;
  logic [DEN_W-1:0]  rem_next;

  // step count per job kind
  always_comb begin
    unique case (req.mode)
      DIV_WARM:   steps = STEP_W'(AVG_W);
      DIV_SMOOTH: steps = STEP_W'(NUM_W);
      DIV_RATIO:  steps = STEP_W'(RSI_W);
      default:    steps = STEP_W'(NUM_W);
    endcase
  end

  // one trial subtract
  always_comb begin
    rem_sh   = {rem, acc[NUM_W-1]};
    trial    = rem_sh - {1'b0, dsr};
    qbit     = ~trial[DEN_W];
    rem_next = qbit ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= rem_init;
      acc <= num;
      dsr <= den;
    end else if (busy) begin
      rem <= rem_next;
      acc <= {acc[NUM_W-2:0], qbit};
    end
  end

  assign quot = acc;

endmodule

`default_nettype wire

// File: hdl/relative_strength_index_filter.sv
// Wilder relative strength index over a stream of q16.16 price samples
//
// Samples enter on sample_valid/sample_ready, results leave on
// result_valid/result_ready; both are valid/ready channels, one beat per item.
// The period register is written by period_we/period_wdata; the user must write
// it only while idle, and the block itself leaves this unchecked.
// sample_ready is high only while the sequencer is idle; each sample then
// takes its own run through one shared serial divider:
//   first sample or warmup sample with no result: difference step only
//   sample that ends warmup: gain and loss sums divided by the period
//   smoothing sample: old gain and loss times period-1, plus the new move,
//   divided by the period
//   both of these then run the ratio divide, which an rsi of 0 or 100 skips
// The divider produces one quotient bit per cycle.
// A result is held in an output register until taken; the next sample is
// accepted while it waits, and its own result stalls at the end of its run.
// Synchronous reset clears the sequencer, series state and result_valid and
// sets the period to 14.
`default_nettype none

module relative_strength_index_filter
  import rsif_pkg::*;
#(
  parameter int unsigned PERIOD_MAX = PERIOD_MAX_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    period_we,
  input  wire logic [PERIOD_REG_W-1:0] period_wdata,
  input  wire logic                    sample_valid,
  output logic                         sample_ready,
  input  wire sample_t                 sample,
  output logic                         result_valid,
  input  wire logic                    result_ready,
  output result_t                      result
);

  localparam int unsigned PW     = $clog2(PERIOD_MAX + 1);
  localparam int unsigned CW     = (PW > PERIOD_REG_W) ? PW : PERIOD_REG_W;
  localparam int unsigned MW     = (PW > RSI_PRE) ? PW : RSI_PRE;
  localparam int unsigned PRD_W  = AVG_W + MW;
  localparam int unsigned NUM_W  = PRD_W + 1;
  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_MUL, ST_DIVLD, ST_DIVRUN,
    ST_RSI, ST_RSILD, ST_RSIRUN, ST_OUT
  } state_t;

  state_t                   state;
  logic [PERIOD_REG_W-1:0]  rsi_period;
  logic signed [PRICE_W-1:0] prev_price;
  logic signed [PRICE_W-1:0] cur_price;
  logic                     cur_last;
  logic                     have_prev;
  logic                     smoothing;
  logic [PW-1:0]            warm_cnt;
  logic [AVG_W-1:0]         gain;
  logic [AVG_W-1:0]         loss;
  logic [ADD_W-1:0]         up_r;
  logic [ADD_W-1:0]         dn_r;
  logic                     side;
  logic [PRD_W-1:0]         prod;
  logic [RSI_W-1:0]         rsi;

  logic [CW-1:0]            per_ext;
  logic [PW-1:0]            p_eff;
  logic signed [PRICE_W:0]  diff;
  logic [PRICE_W:0]         mag;
  logic [ADD_W-1:0]         up;
  logic [ADD_W-1:0]         down;
  logic [AVG_W:0]           gsum;
  logic [AVG_W:0]           lsum;
  logic [AVG_W-1:0]         gsat;
  logic [AVG_W-1:0]         lsat;
  logic [PW:0]              cnt_inc;
  logic                     warm_done;
  logic [AVG_W-1:0]         mul_a;
  logic [MW-1:0]            mul_b;
  logic [PRD_W-1:0]         mul_p;
  div_req_t                 div_req;
  logic [DEN_W-1:0]         div_rem;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic [NUM_W-1:0]         div_quot;
  logic                     div_done;
  logic [AVG_W-1:0]         avg_new;
  logic                     out_free;
  logic                     finishing;
  logic                     clear_now;

  // effective period, clamped to the supported range
  always_comb begin
    per_ext = CW'(rsi_period);
    if (per_ext < CW'(PERIOD_MIN)) begin
      p_eff = PW'(PERIOD_MIN);
    end else if (per_ext > CW'(PERIOD_MAX)) begin
      p_eff = PW'(PERIOD_MAX);
    end else begin
      p_eff = PW'(per_ext);
    end
  end

  // price difference split into gain and loss, scaled to q24.24
  always_comb begin
    diff = {cur_price[PRICE_W-1], cur_price} - {prev_price[PRICE_W-1], prev_price};
    mag  = diff[PRICE_W] ? (~diff + (PRICE_W+1)'(1)) : diff;
    up   = '0;
    down = '0;
    if (diff[PRICE_W]) begin
      down = {mag, {EXTRA_FRAC{1'b0}}};
    end else if (diff != '0) begin
      up = {mag, {EXTRA_FRAC{1'b0}}};
    end
  end

  // saturating warmup sums
  always_comb begin
    gsum = {1'b0, gain} + (AVG_W+1)'(up);
    lsum = {1'b0, loss} + (AVG_W+1)'(down);
    gsat = gsum[AVG_W] ? AVG_MAX : gsum[AVG_W-1:0];
    lsat = lsum[AVG_W] ? AVG_MAX : lsum[AVG_W-1:0];
    cnt_inc   = {1'b0, warm_cnt} + (PW+1)'(1);
    warm_done = cnt_inc >= {1'b0, p_eff};
  end

  // multiplier: average times period-1, or gain times 100
  assign mul_a = ((state == ST_RSI) || !side) ? gain : loss;
  assign mul_b = (state == ST_RSI) ? MW'(RSI_SCALE) : MW'(p_eff - PW'(1));
  assign mul_p = mul_a * mul_b;

  // divider job setup
  always_comb begin
    div_req.start = (state == ST_DIVLD) || (state == ST_RSILD);
    div_rem = '0;
    div_den = DEN_W'(p_eff);
    if (state == ST_RSILD) begin
      div_req.mode = DIV_RATIO;
      div_rem = DEN_W'(prod[AVG_W+RSI_PRE-1:RSI_PRE]);
      div_num = {prod[RSI_PRE-1:0], {RSI_FRAC{1'b0}}, {(NUM_W-RSI_W){1'b0}}};
      div_den = {1'b0, gain} + {1'b0, loss};
    end else if (smoothing) begin
      div_req.mode = DIV_SMOOTH;
      div_num = NUM_W'(prod) + NUM_W'(side ? dn_r : up_r);
    end else begin
      div_req.mode = DIV_WARM;
      div_num = {(side ? loss : gain), {(NUM_W-AVG_W){1'b0}}};
    end
  end

  rsif_div #(
    .NUM_W  (NUM_W),
    .STEP_W (STEP_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .rem_init (div_rem),
    .num      (div_num),
    .den      (div_den),
    .quot     (div_quot),
    .done     (div_done)
  );

  // new average from the quotient, saturated when smoothing
  always_comb begin
    if (smoothing) begin
      avg_new = (div_quot[NUM_W-1:AVG_W] != '0) ? AVG_MAX : div_quot[AVG_W-1:0];
    end else begin
      avg_new = div_quot[AVG_W-1:0];
    end
  end

  // end of a sample and series clearing
  assign out_free  = !result_valid || result_ready;
  assign finishing = ((state == ST_DIFF) && (!have_prev || (!smoothing && !warm_done)))
                     || ((state == ST_OUT) && out_free);
  assign clear_now = ((state == ST_IDLE) && sample_valid && sample.series_start)
                     || (finishing && cur_last);
  assign sample_ready = (state == ST_IDLE);

  // sequencer, series state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rsi_period   <= PERIOD_RST;
      prev_price   <= '0;
      have_prev    <= 1'b0;
      smoothing    <= 1'b0;
      warm_cnt     <= '0;
      gain         <= '0;
      loss         <= '0;
      side         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (period_we) begin
        rsi_period <= period_wdata;
      end
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            cur_price <= sample.price;
            cur_last  <= sample.last_sample;
            state     <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          if (have_prev && !smoothing) begin
            gain     <= gsat;
            loss     <= lsat;
            warm_cnt <= cnt_inc[PW-1:0];
            side     <= 1'b0;
            if (warm_done) begin
              state <= ST_DIVLD;
            end
          end else if (have_prev) begin
            up_r  <= up;
            dn_r  <= down;
            side  <= 1'b0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= mul_p;
          state <= ST_DIVLD;
        end
        ST_DIVLD: begin
          state <= ST_DIVRUN;
        end
        ST_DIVRUN: begin
          if (div_done) begin
            if (!side) begin
              gain  <= avg_new;
              side  <= 1'b1;
              state <= smoothing ? ST_MUL : ST_DIVLD;
            end else begin
              loss      <= avg_new;
              smoothing <= 1'b1;
              state     <= ST_RSI;
            end
          end
        end
        ST_RSI: begin
          if (loss == '0) begin
            rsi   <= RSI_FULL;
            state <= ST_OUT;
          end else if (gain == '0) begin
            rsi   <= '0;
            state <= ST_OUT;
          end else begin
            prod  <= mul_p;
            state <= ST_RSILD;
          end
        end
        ST_RSILD: begin
          state <= ST_RSIRUN;
        end
        ST_RSIRUN: begin
          if (div_done) begin
            rsi   <= div_quot[RSI_W-1:0];
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            result_valid       <= 1'b1;
            result.rsi_value   <= rsi;
            result.series_last <= cur_last;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // sample done: remember its price
      if (finishing) begin
        prev_price <= cur_price;
        have_prev  <= 1'b1;
        state      <= ST_IDLE;
      end

      // series start or end wipes the series state
      if (clear_now) begin
        prev_price <= '0;
        have_prev  <= 1'b0;
        smoothing  <= 1'b0;
        warm_cnt   <= '0;
        gain       <= '0;
        loss       <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/rsif_chk.sv
// port-level checks for the relative strength index filter, bound to the top level
`default_nettype none

module rsif_chk
  import rsif_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    period_we,
  input wire logic [PERIOD_REG_W-1:0] period_wdata,
  input wire logic                    sample_valid,
  input wire logic                    sample_ready,
  input wire sample_t                 sample,
  input wire logic                    result_valid,
  input wire logic                    result_ready,
  input wire result_t                 result
);

  // a sample beat starts a run, so no second beat right behind it
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample accepted on the cycle after a sample beat");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result dropped or changed while stalled");

  // rsi never exceeds 100
  a_rsi_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.rsi_value <= RSI_FULL)
    else $error("rsi above 100");

  // a new result only appears at the end of a run
  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(sample_ready))
    else $error("result appeared while the input side was idle");

endmodule

bind relative_strength_index_filter rsif_chk u_rsif_chk (
  .clk          (clk),
  .rst          (rst),
  .period_we    (period_we),
  .period_wdata (period_wdata),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .sample       (sample),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire
